// ===== src/mpdr_pkg.sv =====
package mpdr_pkg;

  // Field and register widths
  localparam int LEN_W   = 17;
  localparam int SMP_W   = 16;
  localparam int SQ_W    = 30;
  localparam int DC_W    = 17;
  localparam int PSUM_W  = 48;
  localparam int DSUM_W  = 34;
  localparam int DMAG_W  = 33;
  localparam int RES_W   = 32;

  // Length handling
  localparam logic [LEN_W-1:0] LEN_RESET  = 17'd512;
  localparam logic [LEN_W-1:0] MAX_LENGTH = 17'd65536;
  localparam int               GROUP_SIZE = 4;

  // Shared multiplier: 16-bit digits of a 48-bit operand times a 34-bit operand
  localparam int OPA_W    = 48;
  localparam int OPB_W    = 34;
  localparam int DIG_W    = 16;
  localparam int PP_W     = DIG_W + OPB_W;
  localparam int N_DIGITS = OPA_W / DIG_W;
  localparam int ACC_W    = 66;
  localparam int X_W      = 65;
  localparam int Y_W      = 66;
  localparam int DV_W     = 33;

  // Restoring divider
  localparam int DIFF_W    = 66;
  localparam int Q_W       = 33;
  localparam int DIV_STEPS = DIFF_W;
  localparam int DSTEP_W   = 7;

  // Product selector codes
  localparam logic [1:0] MUL_X = 2'd0;
  localparam logic [1:0] MUL_Y = 2'd1;
  localparam logic [1:0] MUL_D = 2'd2;

  typedef struct packed {
    logic       accept;
    logic       load;
    logic       mul_go;
    logic [1:0] mul_sel;
    logic [1:0] mul_dig;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic slot_free;
  } sts_t;

endpackage

// ===== src/mpdr_ctrl.sv =====
module mpdr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  mpdr_pkg::sts_t  sts,
  output mpdr_pkg::cmd_t  cmd
);
  import mpdr_pkg::*;

  localparam logic [2:0] S_ACC   = 3'd0;
  localparam logic [2:0] S_DRAIN = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_DINIT = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic [1:0]         sel_r, sel_nxt;
  logic [1:0]         dig_r, dig_nxt;
  logic [DSTEP_W-1:0] dstep_r, dstep_nxt;

  // Samples are taken only while accumulating.
  assign in_stall = (state_r != S_ACC);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    dig_nxt   = dig_r;
    dstep_nxt = dstep_r;
    cmd       = '0;
    cmd.mul_sel = sel_r;
    cmd.mul_dig = dig_r;
    unique case (state_r)
      S_ACC: begin
        cmd.accept = in_valid;
        if (in_valid && sts.last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        sel_nxt   = MUL_X;
        dig_nxt   = 2'd0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        if (dig_r == 2'(N_DIGITS - 1)) begin
          dig_nxt = 2'd0;
          sel_nxt = sel_r + 2'd1;
          if (sel_r == MUL_D) begin
            state_nxt = S_WAIT;
          end
        end else begin
          dig_nxt = dig_r + 2'd1;
        end
      end
      S_WAIT: begin
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        dstep_nxt    = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dstep_nxt    = dstep_r + DSTEP_W'(1);
        if (dstep_r == DSTEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      sel_r   <= MUL_X;
      dig_r   <= 2'd0;
      dstep_r <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      dig_r   <= dig_nxt;
      dstep_r <= dstep_nxt;
    end
  end

endmodule

// ===== src/mpdr_datapath.sv =====
module mpdr_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [mpdr_pkg::LEN_W-1:0]         cfg_wr_data,
  input  logic signed [mpdr_pkg::SMP_W-1:0]  in_sample_re,
  input  logic signed [mpdr_pkg::SMP_W-1:0]  in_sample_im,
  input  mpdr_pkg::cmd_t                     cmd,
  output mpdr_pkg::sts_t                     sts,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic signed [mpdr_pkg::RES_W-1:0]  out_power_estimate
);
  import mpdr_pkg::*;

  localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

  // Length register and effective length
  logic [LEN_W-1:0] cfg_len_r;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] len_used;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= LEN_RESET;
    end else if (cfg_wr_en) begin
      cfg_len_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (cfg_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (cfg_len_r > MAX_LENGTH) begin
      len_eff = MAX_LENGTH;
    end else begin
      len_eff = cfg_len_r;
    end
  end

  assign len_used = len_eff & ~LEN_W'(GROUP_SIZE - 1);

  // Sample counter; the vector ends once the count reaches the length.
  logic [LEN_W-1:0] cnt_r;
  logic [LEN_W:0]   cnt_inc;
  logic             acc_en;

  assign cnt_inc  = {1'b0, cnt_r} + (LEN_W+1)'(1);
  assign sts.last = (cnt_inc >= {1'b0, len_eff});
  assign acc_en   = (cnt_r < len_used);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.accept) begin
      cnt_r <= sts.last ? '0 : cnt_inc[LEN_W-1:0];
    end
  end

  // Square stage: clip the most negative value, square both parts.
  logic signed [SMP_W-1:0]   re_c, im_c;
  logic signed [2*SMP_W-1:0] sq_re, sq_im;
  logic        [DC_W-1:0]    dc_smp;
  logic                      p_vld_r;
  logic [SQ_W-1:0]           p_sqre_r, p_sqim_r;
  logic [DC_W-1:0]           p_dc_r;

  assign re_c   = (in_sample_re == SMP_MIN) ? SMP_MIN + SMP_W'(1) : in_sample_re;
  assign im_c   = (in_sample_im == SMP_MIN) ? SMP_MIN + SMP_W'(1) : in_sample_im;
  assign sq_re  = re_c * re_c;
  assign sq_im  = im_c * im_c;
  assign dc_smp = {in_sample_re[SMP_W-1], in_sample_re}
                + {in_sample_im[SMP_W-1], in_sample_im};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= cmd.accept & acc_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p_sqre_r <= sq_re[SQ_W-1:0];
      p_sqim_r <= sq_im[SQ_W-1:0];
      p_dc_r   <= dc_smp;
    end
  end

  // Running sums, cleared when the end-of-vector operands are taken.
  logic [PSUM_W-1:0] psum_r;
  logic [DSUM_W-1:0] dsum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psum_r <= '0;
      dsum_r <= '0;
    end else if (cmd.load) begin
      psum_r <= '0;
      dsum_r <= '0;
    end else if (p_vld_r) begin
      psum_r <= psum_r + PSUM_W'(p_sqre_r) + PSUM_W'(p_sqim_r);
      dsum_r <= dsum_r + {{(DSUM_W-DC_W){p_dc_r[DC_W-1]}}, p_dc_r};
    end
  end

  // Operand latch for the end-of-vector computation
  logic [PSUM_W-1:0] pw_r;
  logic [DMAG_W-1:0] dmag_r;
  logic [LEN_W-1:0]  len_r;
  logic [DSUM_W-1:0] dabs;

  assign dabs = dsum_r[DSUM_W-1] ? (DSUM_W'(0) - dsum_r) : dsum_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pw_r   <= psum_r;
      dmag_r <= dabs[DMAG_W-1:0];
      len_r  <= len_eff;
    end
  end

  // Shared multiplier: one 16-bit digit of operand A per cycle.
  logic [OPA_W-1:0] opa;
  logic [OPB_W-1:0] opb;
  logic [DIG_W-1:0] dig;
  logic [PP_W-1:0]  pp;
  logic [PP_W-1:0]  pp_r;
  logic [1:0]       pp_sel_r, pp_dig_r;
  logic             pp_vld_r;

  always_comb begin
    case (cmd.mul_sel)
      MUL_X: begin
        opa = pw_r;
        opb = OPB_W'(len_r);
      end
      MUL_Y: begin
        opa = OPA_W'(dmag_r);
        opb = OPB_W'(dmag_r);
      end
      MUL_D: begin
        opa = OPA_W'(len_r);
        opb = OPB_W'(len_r);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_comb begin
    case (cmd.mul_dig)
      2'd0:    dig = opa[DIG_W-1:0];
      2'd1:    dig = opa[2*DIG_W-1:DIG_W];
      default: dig = opa[3*DIG_W-1:2*DIG_W];
    endcase
  end

  assign pp = PP_W'(dig) * PP_W'(opb);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_vld_r <= 1'b0;
    end else begin
      pp_vld_r <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      pp_r     <= pp;
      pp_sel_r <= cmd.mul_sel;
      pp_dig_r <= cmd.mul_dig;
    end
  end

  // Accumulate shifted partial products into the selected product.
  logic [X_W-1:0]   x_r;
  logic [Y_W-1:0]   y_r;
  logic [DV_W-1:0]  dv_r;
  logic [ACC_W-1:0] pp_sh, acc_cur, acc_sum;

  always_comb begin
    case (pp_dig_r)
      2'd0:    pp_sh = ACC_W'(pp_r);
      2'd1:    pp_sh = ACC_W'({pp_r, {DIG_W{1'b0}}});
      default: pp_sh = ACC_W'({pp_r, {(2*DIG_W){1'b0}}});
    endcase
  end

  always_comb begin
    case (pp_sel_r)
      MUL_X:   acc_cur = ACC_W'(x_r);
      MUL_Y:   acc_cur = ACC_W'(y_r);
      default: acc_cur = ACC_W'(dv_r);
    endcase
  end

  assign acc_sum = acc_cur + pp_sh;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r  <= '0;
      y_r  <= '0;
      dv_r <= '0;
    end else if (pp_vld_r) begin
      case (pp_sel_r)
        MUL_X:   x_r  <= acc_sum[X_W-1:0];
        MUL_Y:   y_r  <= acc_sum[Y_W-1:0];
        default: dv_r <= acc_sum[DV_W-1:0];
      endcase
    end
  end

  // Restoring divider: |P*L - D^2| / L^2, one quotient bit per cycle.
  logic [DIFF_W-1:0] x_ext;
  logic              neg_r;
  logic [DIFF_W-1:0] diff_r;
  logic [DV_W-1:0]   rem_r;
  logic [Q_W-1:0]    q_r;
  logic              ovf_r;
  logic [DV_W:0]     rem_sh;
  logic              rem_ge;
  logic [DV_W:0]     rem_sub;

  assign x_ext   = DIFF_W'(x_r);
  assign rem_sh  = {rem_r, diff_r[DIFF_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dv_r});
  assign rem_sub = rem_sh - {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg_r  <= (x_ext < y_r);
      diff_r <= (x_ext < y_r) ? (y_r - x_ext) : (x_ext - y_r);
      rem_r  <= '0;
      q_r    <= '0;
      ovf_r  <= 1'b0;
    end else if (cmd.div_step) begin
      diff_r <= {diff_r[DIFF_W-2:0], 1'b0};
      rem_r  <= rem_ge ? rem_sub[DV_W-1:0] : rem_sh[DV_W-1:0];
      q_r    <= {q_r[Q_W-2:0], rem_ge};
      ovf_r  <= ovf_r | q_r[Q_W-1];
    end
  end

  // Sign and saturation of the quotient
  logic [RES_W-1:0] res;
  logic             sat_pos, sat_neg;

  assign sat_pos = ovf_r | q_r[Q_W-1] | q_r[RES_W-1];
  assign sat_neg = ovf_r | q_r[Q_W-1] | (q_r[RES_W-1] & (|q_r[RES_W-2:0]));

  always_comb begin
    if (neg_r) begin
      res = sat_neg ? {1'b1, {(RES_W-1){1'b0}}} : (RES_W'(0) - q_r[RES_W-1:0]);
    end else begin
      res = sat_pos ? {1'b0, {(RES_W-1){1'b1}}} : q_r[RES_W-1:0];
    end
  end

  // Output register
  logic                    out_vld_r;
  logic signed [RES_W-1:0] out_pe_r;

  assign sts.slot_free = ~out_vld_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pe_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_power_estimate = out_pe_r;

endmodule

// ===== src/mean_power_dc_removed.sv =====
// Throughput: one sample per cycle while a vector is being accumulated.
// After the vector's last sample is taken, the shared 16x34 multiplier and the 66-step
// restoring divider compute its result, which is then registered and raises out_valid.
// in_stall stays high from the last sample of a vector until its result is registered.
// Reset (synchronous, rst_n low): sums and count clear, length returns to 512,
// no result is pending.
module mean_power_dc_removed (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [mpdr_pkg::LEN_W-1:0]         cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [mpdr_pkg::SMP_W-1:0]  in_sample_re,
  input  logic signed [mpdr_pkg::SMP_W-1:0]  in_sample_im,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [mpdr_pkg::RES_W-1:0]  out_power_estimate
);
  import mpdr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  mpdr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Accumulators, multiplier, divider and output register
  mpdr_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_sample_re       (in_sample_re),
    .in_sample_im       (in_sample_im),
    .cmd                (cmd),
    .sts                (sts),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_power_estimate (out_power_estimate)
  );

endmodule

// ===== src/mpdr_checker.sv =====
module mpdr_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [mpdr_pkg::RES_W-1:0]  out_power_estimate
);
  import mpdr_pkg::*;

  // Reset leaves no result pending and the input open.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("reset did not clear the output and open the input");

  // A stalled result beat stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_power_estimate))
    else $error("result changed while stalled");

  // A new result comes only out of the compute phase, with the input stalled.
  a_result_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(in_stall) && $past(in_stall, 2)))
    else $error("result appeared without a compute phase");

endmodule

bind mean_power_dc_removed mpdr_checker u_mpdr_checker (.*);

// ===== sim/mean_power_dc_removed_tb.sv =====
`timescale 1ns / 1ps

module mean_power_dc_removed_tb;
  import mpdr_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int SETTLE_CYCLES = 120;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int ITEMS_PER_MODE = 517;
  localparam int HOLD_CYCLES   = 400;

  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;
  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
  localparam logic [LEN_W-1:0]        LEN_ALL_ONES = '1;

  // Tracks the running sums of the current vector and queues the estimates it predicts.
  class power_scoreboard;
    logic [LEN_W-1:0]          length_reg;
    bit [PSUM_W-1:0]           pow_acc;
    longint                    dc_acc;
    int unsigned               count_in_vector;
    logic signed [RES_W-1:0]   estimate_q[$];
    int                        errors;

    function new();
      errors = 0;
      reset_state();
    endfunction

    function void reset_state();
      length_reg = LEN_RESET;
      pow_acc = '0;
      dc_acc = 0;
      count_in_vector = 0;
      estimate_q.delete();
    endfunction

    function void set_length(logic [LEN_W-1:0] value);
      length_reg = value;
    endfunction

    function int unsigned eff_length();
      if (length_reg == '0) return 1;
      if (length_reg > MAX_LENGTH) return int'(MAX_LENGTH);
      return int'(length_reg);
    endfunction

    function int pending();
      return estimate_q.size();
    endfunction

    // Accumulate one accepted sample and predict the estimate when the vector ends.
    function void note_sample(logic signed [SMP_W-1:0] re, logic signed [SMP_W-1:0] im);
      int unsigned len;
      int unsigned used;
      int          r;
      int          i;
      int          rc;
      int          ic;
      bit [63:0]   dmag;
      bit [127:0]  x;
      bit [127:0]  y;
      bit [127:0]  dv;
      bit [127:0]  q;
      longint      est;
      len = eff_length();
      used = len - (len % GROUP_SIZE);
      r = re;
      i = im;
      if (count_in_vector < used) begin
        rc = (r == -32768) ? -32767 : r;
        ic = (i == -32768) ? -32767 : i;
        pow_acc += PSUM_W'(rc * rc) + PSUM_W'(ic * ic);
        dc_acc += r + i;
      end
      count_in_vector++;
      if (count_in_vector < len) return;

      // Exact (P*L - D^2) / L^2, truncated toward zero and saturated.
      dmag = (dc_acc < 0) ? 64'(-dc_acc) : 64'(dc_acc);
      x = 128'(pow_acc) * 128'(len);
      y = 128'(dmag) * 128'(dmag);
      dv = 128'(len) * 128'(len);
      if (x < y) begin
        q = (y - x) / dv;
        est = (q > 128'd2147483648) ? -64'sd2147483648 : -longint'(q[63:0]);
      end else begin
        q = (x - y) / dv;
        est = (q > 128'd2147483647) ? 64'sd2147483647 : longint'(q[63:0]);
      end
      estimate_q.push_back(est[RES_W-1:0]);
      pow_acc = '0;
      dc_acc = 0;
      count_in_vector = 0;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one result beat with the oldest predicted estimate.
    task check_result(logic signed [RES_W-1:0] got);
      logic signed [RES_W-1:0] want;
      if (estimate_q.size() == 0) begin
        report_mismatch($sformatf("unexpected power_estimate %0d", got));
      end else begin
        want = estimate_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf("power_estimate %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [LEN_W-1:0]         cfg_wr_data;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [SMP_W-1:0]  in_sample_re;
  logic signed [SMP_W-1:0]  in_sample_im;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [RES_W-1:0]  out_power_estimate;

  power_scoreboard sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int cycle_count;

  mean_power_dc_removed u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample_re       (in_sample_re),
    .in_sample_im       (in_sample_im),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_power_estimate (out_power_estimate)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Give up after a generous number of cycles.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result side stall: a long hold-off when requested, random stalls otherwise.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Check every result beat taken at a rising edge.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_power_estimate);
    end
  end

  // Offer one sample beat, with random idle cycles first, and wait until it is taken.
  task send_sample(logic signed [SMP_W-1:0] re, logic signed [SMP_W-1:0] im);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_re <= re;
    in_sample_im <= im;
    do @(posedge clk); while (in_stall);
    sb.note_sample(re, im);
  endtask

  // Stop sending, wait for every predicted estimate, then let the pipeline settle.
  task drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_length(logic [LEN_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_length(value);
  endtask

  // Corner, small and random values, with an optional DC offset shared by a whole burst.
  function automatic logic signed [SMP_W-1:0] pick_sample(logic signed [SMP_W-1:0] bias,
                                                           bit biased);
    int r;
    r = $urandom_range(0, 99);
    if (biased && r < 60) return bias + SMP_W'($urandom_range(0, 15));
    if (r < 10) return SMP_MIN;
    if (r < 18) return SMP_MAX;
    if (r < 22) return '0;
    if (r < 35) return SMP_W'(int'($urandom_range(0, 63)) - 32);
    return SMP_W'($urandom);
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return LEN_W'($urandom_range(0, 4));
    if (r < 50) return LEN_W'($urandom_range(5, 16));
    if (r < 80) return LEN_W'($urandom_range(17, 100));
    if (r < 85) return MAX_LENGTH;
    if (r < 88) return LEN_ALL_ONES;
    return LEN_W'($urandom_range(129, 131071));
  endfunction

  // One burst: new length, then whole vectors, a partial vector, or a cut vector.
  task random_burst(inout int items_left);
    int unsigned eff;
    int unsigned rem;
    int unsigned n;
    logic signed [SMP_W-1:0] bias;
    bit biased;
    write_length(pick_length());
    eff = sb.eff_length();
    rem = (sb.count_in_vector >= eff) ? 1 : eff - sb.count_in_vector;
    if (eff <= 128) begin
      n = rem + eff * $urandom_range(0, 3);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, rem);
    end else begin
      n = $urandom_range(1, (rem < 60) ? rem : 60);
    end
    // Keep the total close to the planned item count.
    if (n > unsigned'(items_left)) n = unsigned'(items_left);
    biased = ($urandom_range(0, 4) == 0);
    bias = pick_sample('0, 1'b0);
    repeat (n) send_sample(pick_sample(bias, biased), pick_sample(bias, biased));
    items_left -= n;
    drain();
  endtask

  initial begin
    int items_left;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_sample_re = '0;
    in_sample_im = '0;
    hold_left = 0;
    send_idle_pct = 9;
    recv_idle_pct = 47;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero length acts as one: every sample ends a vector with a zero estimate.
    write_length('0);
    send_sample(SMP_MIN, SMP_MIN);
    send_sample(SMP_MAX, SMP_MAX);
    drain();

    // Length five: four accumulated corner samples and one ignored tail sample.
    write_length(LEN_W'(5));
    send_sample(SMP_MIN, SMP_MAX);
    send_sample(SMP_MAX, SMP_MIN);
    send_sample(SMP_MIN, SMP_MIN);
    send_sample('0, '0);
    send_sample(SMP_MIN, SMP_MIN);
    drain();

    // Overlong length, then a cut to one: large power saturates high.
    write_length(LEN_ALL_ONES);
    repeat (4) send_sample(SMP_MAX, SMP_MIN);
    drain();
    write_length(LEN_W'(1));
    send_sample('0, '0);
    drain();

    // Maximum length, then a cut to two: large DC saturates low.
    write_length(MAX_LENGTH);
    repeat (4) send_sample(SMP_MIN, SMP_MIN);
    drain();
    write_length(LEN_W'(2));
    send_sample(SMP_MAX, SMP_MAX);
    drain();

    // One full group without a tail, then a length with only tail samples.
    write_length(LEN_W'(4));
    send_sample(SMP_MAX, '0);
    send_sample('0, SMP_MIN);
    send_sample(16'sd1234, -16'sd4321);
    send_sample(-16'sd1, 16'sd1);
    drain();
    write_length(LEN_W'(3));
    repeat (3) send_sample(SMP_MAX, SMP_MIN);
    drain();

    // Random bursts under three stall patterns.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 47;
        end
        1: begin
          send_idle_pct = 47;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      items_left = ITEMS_PER_MODE;
      if (mode == 2) begin
        // Hold the result side off while short vectors keep arriving.
        write_length(LEN_W'(2));
        hold_left = HOLD_CYCLES;
        repeat (30) send_sample(pick_sample('0, 1'b0), pick_sample('0, 1'b0));
        items_left -= 30;
        drain();
      end
      while (items_left > 0) random_burst(items_left);
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
